// ===== rtl/cdhri_pkg.sv =====
// Shared types, codes and helpers for the disc-drive host register interface.
// Depends on nothing; the top level takes its beat structs and codes from here.
`default_nettype none

package cdhri_pkg;

	// Default sizes of the FIFOs and the sector ring
	localparam int unsigned PARAM_DEPTH_DEF  = 16;
	localparam int unsigned RESP_DEPTH_DEF   = 16;
	localparam int unsigned SECTOR_BYTES_DEF = 2352;

	localparam int unsigned IRQ_W = 5;

	// Item opcodes
	localparam logic [2:0] OP_HOST_READ  = 3'd0;
	localparam logic [2:0] OP_HOST_WRITE = 3'd1;
	localparam logic [2:0] OP_PUSH_RESP  = 3'd2;
	localparam logic [2:0] OP_POP_PARAM  = 3'd3;
	localparam logic [2:0] OP_PUSH_DATA  = 3'd4;
	localparam logic [2:0] OP_SET_IRQ    = 3'd5;

	// Host ports
	localparam logic [1:0] PORT_STATUS     = 2'd0;
	localparam logic [1:0] PORT_CMD_RESP   = 2'd1;
	localparam logic [1:0] PORT_PARAM_DATA = 2'd2;
	localparam logic [1:0] PORT_IRQ_REQ    = 2'd3;

	// Banks selected by the index register
	localparam logic [1:0] BANK0 = 2'd0;
	localparam logic [1:0] BANK1 = 2'd1;
	localparam logic [1:0] BANK2 = 2'd2;
	localparam logic [1:0] BANK3 = 2'd3;

	// Mix volume slots
	localparam logic [1:0] VOL_LL = 2'd0;
	localparam logic [1:0] VOL_LR = 2'd1;
	localparam logic [1:0] VOL_RL = 2'd2;
	localparam logic [1:0] VOL_RR = 2'd3;

	// Source of the read byte in the result stage
	localparam logic [1:0] SRC_REG  = 2'd0;
	localparam logic [1:0] SRC_RESP = 2'd1;
	localparam logic [1:0] SRC_DATA = 2'd2;

	typedef struct packed {
		logic [2:0] opcode;
		logic [1:0] port_address;
		logic [7:0] byte_value;
	} req_t;

	typedef struct packed {
		logic [7:0]       read_data;
		logic [7:0]       popped_parameter;
		logic             command_strobe;
		logic [7:0]       command_code;
		logic [2:0]       request_bits;
		logic [IRQ_W-1:0] irq_enable_mask;
		logic [IRQ_W-1:0] irq_pending;
	} res_t;

	// Interrupt flag read: code of a one-hot flag in bits 2..0, flag bits 4 and 3 echoed
	function automatic logic [7:0] flag_byte(input logic [IRQ_W-1:0] f);
		logic [2:0] code;
		case (f)
			5'h01:   code = 3'd1;
			5'h02:   code = 3'd2;
			5'h04:   code = 3'd3;
			5'h08:   code = 3'd4;
			5'h10:   code = 3'd5;
			default: code = 3'd0;
		endcase
		return {3'b111, f[4], f[3], code};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/cdrom_host_register_interface_unit.sv =====
// Host register interface of a disc-drive controller: banked byte ports, FIFOs, sector ring.
// Depends on cdhri_pkg for beat structs, codes and the interrupt flag encoding.
//
// Usage:
//   req channel (req_valid/req_stall/req) carries one host bus access or one
//   firmware event per beat: host read, host write, push response, pop
//   parameter, push data, set interrupt bits. Every beat yields exactly one
//   beat on the res channel (res_valid/res_stall/res) in the same order.
//   An accepted beat passes the result stage, then the output register. The
//   response, parameter and sector memories are read at the accept edge and
//   their registered data are merged in the following cycle.
//   Throughput: one beat per cycle while res is not stalled. Each beat writes
//   at most one memory slot, so back-to-back beats never contend for a memory port.
//   Stall: while res_stall holds a result in the output register, the result
//   stage takes one more beat; req_stall then rises until res drains.
//   Reset: pointers, flags, latches and the response valid bits clear at
//   once; there is no clearing pass. Sector contents are undefined until
//   written; response slots never written read as zero.
`default_nettype none

module cdrom_host_register_interface_unit #(
	parameter int unsigned PARAM_DEPTH  = cdhri_pkg::PARAM_DEPTH_DEF,
	parameter int unsigned RESP_DEPTH   = cdhri_pkg::RESP_DEPTH_DEF,
	parameter int unsigned SECTOR_BYTES = cdhri_pkg::SECTOR_BYTES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire cdhri_pkg::req_t req,
	output logic                res_valid,
	input  wire logic           res_stall,
	output cdhri_pkg::res_t     res
);
	import cdhri_pkg::*;

	localparam int unsigned PW = $clog2(PARAM_DEPTH);
	localparam int unsigned RW = $clog2(RESP_DEPTH);
	localparam int unsigned SW = $clog2(SECTOR_BYTES);

	// Architectural registers
	logic [1:0]       bank_q;
	logic [7:0]       cmd_q;
	logic [2:0]       request_q;
	logic [IRQ_W-1:0] irq_en_q;
	logic [IRQ_W-1:0] irq_flag_q;
	logic [7:0]       last_param_q;
	logic [7:0]       vol_q [4];

	logic [PW-1:0]    prm_rd_ptr_q, prm_wr_ptr_q, prm_rd_nxt, prm_wr_nxt;
	logic             prm_empty_q;
	logic [RW-1:0]    rsp_rd_ptr_q, rsp_wr_ptr_q, rsp_rd_nxt, rsp_wr_nxt;
	logic [RESP_DEPTH-1:0] rsp_vld_q;
	logic [SW-1:0]    dat_rd_ptr_q, dat_wr_ptr_q, dat_rd_nxt, dat_wr_nxt;

	// Memories
	logic [7:0] prm_mem [PARAM_DEPTH];
	logic [7:0] rsp_mem [RESP_DEPTH];
	logic [7:0] dat_mem [SECTOR_BYTES];

	// Accept-side decode
	logic       accept;
	logic       is_rd, is_wr;
	logic       prm_full, rsp_empty, rsp_full, dat_empty, dat_full;
	logic       prm_push, prm_pop, rsp_push, rsp_pop, dat_push, dat_pop;
	logic       cmd_wr, bank_wr, irq_en_wr, irq_clr, irq_set, request_wr;
	logic       vol_wr;
	logic [1:0] vol_sel;
	logic [7:0] reg_byte;
	logic [1:0] src;
	logic [7:0] v;

	// Result stage
	logic       s1_valid_q;
	logic [1:0] src_s1;
	logic [7:0] reg_byte_s1;
	logic       strobe_s1;
	logic       pop_s1;
	logic       rsp_hit_s1;
	logic [7:0] prm_rd_s1, rsp_rd_s1, dat_rd_s1;
	logic [7:0] rd_byte;
	logic [7:0] popped;
	logic       out_ready, move;

	logic       res_valid_q;
	res_t       res_q;

	assign v = req.byte_value;

	// Handshake: result stage drains into the output register
	assign out_ready = !res_valid_q || !res_stall;
	assign move      = s1_valid_q && out_ready;
	assign req_stall = s1_valid_q && !out_ready;
	assign accept    = req_valid && !req_stall;

	// Ring pointer increments with wrap
	assign prm_wr_nxt = (prm_wr_ptr_q == PW'(PARAM_DEPTH - 1)) ? '0 : prm_wr_ptr_q + PW'(1);
	assign prm_rd_nxt = (prm_rd_ptr_q == PW'(PARAM_DEPTH - 1)) ? '0 : prm_rd_ptr_q + PW'(1);
	assign rsp_wr_nxt = (rsp_wr_ptr_q == RW'(RESP_DEPTH - 1)) ? '0 : rsp_wr_ptr_q + RW'(1);
	assign rsp_rd_nxt = (rsp_rd_ptr_q == RW'(RESP_DEPTH - 1)) ? '0 : rsp_rd_ptr_q + RW'(1);
	assign dat_wr_nxt = (dat_wr_ptr_q == SW'(SECTOR_BYTES - 1)) ? '0 : dat_wr_ptr_q + SW'(1);
	assign dat_rd_nxt = (dat_rd_ptr_q == SW'(SECTOR_BYTES - 1)) ? '0 : dat_rd_ptr_q + SW'(1);

	assign prm_full  = (prm_wr_nxt == prm_rd_ptr_q);
	assign rsp_empty = (rsp_wr_ptr_q == rsp_rd_ptr_q);
	assign rsp_full  = (rsp_wr_nxt == rsp_rd_ptr_q);
	assign dat_empty = (dat_wr_ptr_q == dat_rd_ptr_q);
	assign dat_full  = (dat_wr_nxt == dat_rd_ptr_q);

	assign is_rd = accept && (req.opcode == OP_HOST_READ);
	assign is_wr = accept && (req.opcode == OP_HOST_WRITE);

	// Firmware events and FIFO moves
	assign rsp_push = accept && (req.opcode == OP_PUSH_RESP) && !rsp_full;
	assign prm_pop  = accept && (req.opcode == OP_POP_PARAM) && !prm_empty_q;
	assign dat_push = accept && (req.opcode == OP_PUSH_DATA) && !dat_full;
	assign irq_set  = accept && (req.opcode == OP_SET_IRQ);
	assign rsp_pop  = is_rd && (req.port_address == PORT_CMD_RESP) && !rsp_empty;
	assign dat_pop  = is_rd && (req.port_address == PORT_PARAM_DATA) && !dat_empty;

	// Decode host writes by port and bank
	always_comb begin
		bank_wr    = 1'b0;
		cmd_wr     = 1'b0;
		prm_push   = 1'b0;
		irq_en_wr  = 1'b0;
		irq_clr    = 1'b0;
		request_wr = 1'b0;
		vol_wr     = 1'b0;
		vol_sel    = VOL_LL;
		if (is_wr) begin
			unique case (req.port_address)
				PORT_STATUS: begin
					bank_wr = 1'b1;
				end
				PORT_CMD_RESP: begin
					if (bank_q == BANK0) begin
						cmd_wr = 1'b1;
					end else if (bank_q == BANK3) begin
						vol_wr  = 1'b1;
						vol_sel = VOL_RR;
					end
				end
				PORT_PARAM_DATA: begin
					unique case (bank_q)
						BANK0: prm_push = !prm_full;
						BANK1: irq_en_wr = 1'b1;
						BANK2: begin
							vol_wr  = 1'b1;
							vol_sel = VOL_LL;
						end
						default: begin
							vol_wr  = 1'b1;
							vol_sel = VOL_RL;
						end
					endcase
				end
				default: begin
					unique case (bank_q)
						BANK0: request_wr = 1'b1;
						BANK1: irq_clr = 1'b1;
						BANK2: begin
							vol_wr  = 1'b1;
							vol_sel = VOL_LR;
						end
						default: ;
					endcase
				end
			endcase
		end
	end

	// Form the register part of a host read and pick its source
	always_comb begin
		reg_byte = 8'h00;
		src      = SRC_REG;
		if (is_rd) begin
			unique case (req.port_address)
				PORT_STATUS: reg_byte = {1'b0, !dat_empty, !rsp_empty, !prm_full,
				                         prm_empty_q, 1'b0, bank_q};
				PORT_CMD_RESP: src = SRC_RESP;
				PORT_PARAM_DATA: src = SRC_DATA;
				default: reg_byte = bank_q[0] ? flag_byte(irq_flag_q) : {3'b111, irq_en_q};
			endcase
		end
	end

	// Update latches, pointers and flags on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q       <= '0;
			cmd_q        <= '0;
			request_q    <= '0;
			irq_en_q     <= '0;
			irq_flag_q   <= '0;
			prm_rd_ptr_q <= '0;
			prm_wr_ptr_q <= '0;
			prm_empty_q  <= 1'b1;
			rsp_rd_ptr_q <= '0;
			rsp_wr_ptr_q <= '0;
			rsp_vld_q    <= '0;
			dat_rd_ptr_q <= '0;
			dat_wr_ptr_q <= '0;
			for (int i = 0; i < 4; i++) begin
				vol_q[i] <= '0;
			end
		end else begin
			if (bank_wr) bank_q <= v[1:0];
			if (cmd_wr) cmd_q <= v;
			if (request_wr) request_q <= v[7:5];
			if (irq_en_wr) irq_en_q <= v[IRQ_W-1:0];
			if (irq_set) irq_flag_q <= irq_flag_q | v[IRQ_W-1:0];
			if (irq_clr) irq_flag_q <= irq_flag_q & ~v[IRQ_W-1:0];
			if (vol_wr) vol_q[vol_sel] <= v;
			if (prm_push) prm_wr_ptr_q <= prm_wr_nxt;
			if (prm_pop) prm_rd_ptr_q <= prm_rd_nxt;
			if (prm_push) begin
				prm_empty_q <= 1'b0;
			end else if (prm_pop) begin
				prm_empty_q <= (prm_rd_nxt == prm_wr_ptr_q);
			end
			if (rsp_push) begin
				rsp_wr_ptr_q            <= rsp_wr_nxt;
				rsp_vld_q[rsp_wr_ptr_q] <= 1'b1;
			end
			if (rsp_pop) rsp_rd_ptr_q <= rsp_rd_nxt;
			if (dat_push) dat_wr_ptr_q <= dat_wr_nxt;
			if (dat_pop) dat_rd_ptr_q <= dat_rd_nxt;
		end
	end

	// Parameter memory: write on push, read at the read pointer on accept
	always_ff @(posedge clk) begin
		if (prm_push) prm_mem[prm_wr_ptr_q] <= v;
		if (accept) prm_rd_s1 <= prm_mem[prm_rd_ptr_q];
	end

	// Response memory
	always_ff @(posedge clk) begin
		if (rsp_push) rsp_mem[rsp_wr_ptr_q] <= v;
		if (accept) rsp_rd_s1 <= rsp_mem[rsp_rd_ptr_q];
	end

	// Sector ring memory
	always_ff @(posedge clk) begin
		if (dat_push) dat_mem[dat_wr_ptr_q] <= v;
		if (accept) dat_rd_s1 <= dat_mem[dat_rd_ptr_q];
	end

	// Hold the accepted beat's control until the memory data arrive
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (move) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			src_s1      <= src;
			reg_byte_s1 <= reg_byte;
			strobe_s1   <= cmd_wr;
			pop_s1      <= prm_pop;
			rsp_hit_s1  <= rsp_vld_q[rsp_rd_ptr_q];
		end
	end

	// Merge memory data into the read byte
	always_comb begin
		case (src_s1)
			SRC_RESP: rd_byte = rsp_hit_s1 ? rsp_rd_s1 : 8'h00;
			SRC_DATA: rd_byte = dat_rd_s1;
			default:  rd_byte = reg_byte_s1;
		endcase
	end

	assign popped = pop_s1 ? prm_rd_s1 : last_param_q;

	// Retire the popped parameter as the beat leaves the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_param_q <= '0;
		end else if (move && pop_s1) begin
			last_param_q <= prm_rd_s1;
		end
	end

	// Output register; latches already hold this beat's values at the move edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_ready) begin
			res_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			res_q.read_data        <= rd_byte;
			res_q.popped_parameter <= popped;
			res_q.command_strobe   <= strobe_s1;
			res_q.command_code     <= cmd_q;
			res_q.request_bits     <= request_q;
			res_q.irq_enable_mask  <= irq_en_q;
			res_q.irq_pending      <= irq_flag_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	// A beat held in the result stage is never lost while the output is blocked
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !out_ready |=> s1_valid_q)
		else $error("result stage dropped a beat");

	// Back-pressure only arises from an occupied result stage
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> s1_valid_q && res_valid_q)
		else $error("input stalled with free stages");

	// Empty parameter flag agrees with the pointers
	a_prm_empty: assert property (@(posedge clk) disable iff (!arst_n)
		prm_empty_q |-> prm_rd_ptr_q == prm_wr_ptr_q)
		else $error("parameter empty flag out of step with pointers");

	// Sector pointers stay inside the ring
	a_dat_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(dat_wr_ptr_q) < SECTOR_BYTES) && (32'(dat_rd_ptr_q) < SECTOR_BYTES))
		else $error("sector pointer outside ring");

	// A command write reaches the result stage with its strobe at the next edge
	a_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd_wr && out_ready |=> s1_valid_q && strobe_s1)
		else $error("command write not carried to result stage");
`endif

endmodule

`default_nettype wire

// ===== dv/cdhri_reply_check.sv =====
// Reply checker for the disc-drive host register interface: watches both beat channels,
// keeps its own copy of the port, FIFO, ring and interrupt state and compares every reply.
// Depends on cdhri_pkg for the beat structs, opcodes, ports, banks and volume slots.
module cdhri_reply_check #(
	parameter int unsigned PARAM_DEPTH  = cdhri_pkg::PARAM_DEPTH_DEF,
	parameter int unsigned RESP_DEPTH   = cdhri_pkg::RESP_DEPTH_DEF,
	parameter int unsigned SECTOR_BYTES = cdhri_pkg::SECTOR_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_stall,
	input  cdhri_pkg::req_t req,
	input  logic            res_valid,
	input  logic            res_stall,
	input  cdhri_pkg::res_t res,
	output int              fail_count,
	output int              open_replies
);
	timeunit 1ns;
	timeprecision 1ps;
	import cdhri_pkg::*;

	localparam int PW = $clog2(PARAM_DEPTH);
	localparam int RW = $clog2(RESP_DEPTH);
	localparam int SW = $clog2(SECTOR_BYTES);

	// Shadow of the block's state
	logic [1:0]       bank;
	logic [7:0]       par_mem [PARAM_DEPTH];
	logic [PW-1:0]    par_rd, par_wr;
	logic             par_empty;
	logic [7:0]       par_last;
	logic [7:0]       rsp_mem [RESP_DEPTH];
	logic [RW-1:0]    rsp_rd, rsp_wr;
	logic [7:0]       sec_mem [SECTOR_BYTES];
	logic [SW-1:0]    sec_rd, sec_wr;
	logic [7:0]       cmd_latch;
	logic [IRQ_W-1:0] irq_en, irq_flag;
	logic [2:0]       req_bits;
	logic [7:0]       vol [4];

	res_t due_replies [$];
	int   errs = 0;

	function automatic int unsigned step_ptr(int unsigned p, int unsigned depth);
		return (p + 1 >= depth) ? 0 : p + 1;
	endfunction

	// Apply one access or firmware event to the shadow and return the reply it yields
	function automatic res_t predict_reply(req_t it);
		res_t       r;
		logic [2:0] code;
		logic [7:0] v;
		v = it.byte_value;
		r = '0;
		case (it.opcode)
			OP_HOST_READ: begin
				case (it.port_address)
					PORT_STATUS: begin
						r.read_data = {1'b0, sec_wr != sec_rd, rsp_wr != rsp_rd,
							PW'(step_ptr(32'(par_wr), PARAM_DEPTH)) != par_rd, par_empty,
							1'b0, bank};
					end
					PORT_CMD_RESP: begin
						r.read_data = rsp_mem[rsp_rd];
						if (rsp_wr != rsp_rd)
							rsp_rd = RW'(step_ptr(32'(rsp_rd), RESP_DEPTH));
					end
					PORT_PARAM_DATA: begin
						r.read_data = sec_mem[sec_rd];
						if (sec_wr != sec_rd)
							sec_rd = SW'(step_ptr(32'(sec_rd), SECTOR_BYTES));
					end
					default: begin
						// one-hot flag gives its bit number plus one, anything else zero
						case (irq_flag)
							5'h01:   code = 3'd1;
							5'h02:   code = 3'd2;
							5'h04:   code = 3'd3;
							5'h08:   code = 3'd4;
							5'h10:   code = 3'd5;
							default: code = 3'd0;
						endcase
						r.read_data = bank[0] ? {3'b111, irq_flag[4], irq_flag[3], code}
							: {3'b111, irq_en};
					end
				endcase
			end
			OP_HOST_WRITE: begin
				if (it.port_address == PORT_STATUS) begin
					bank = v[1:0];
				end else begin
					case ({it.port_address, bank})
						{PORT_CMD_RESP, BANK0}: begin
							cmd_latch = v;
							r.command_strobe = 1'b1;
						end
						{PORT_CMD_RESP, BANK3}: vol[VOL_RR] = v;
						{PORT_PARAM_DATA, BANK0}: begin
							// drop the push when the parameter FIFO is full
							if (PW'(step_ptr(32'(par_wr), PARAM_DEPTH)) != par_rd) begin
								par_mem[par_wr] = v;
								par_wr = PW'(step_ptr(32'(par_wr), PARAM_DEPTH));
								par_empty = 1'b0;
							end
						end
						{PORT_PARAM_DATA, BANK1}: irq_en = v[4:0];
						{PORT_PARAM_DATA, BANK2}: vol[VOL_LL] = v;
						{PORT_PARAM_DATA, BANK3}: vol[VOL_RL] = v;
						{PORT_IRQ_REQ, BANK0}:    req_bits = v[7:5];
						{PORT_IRQ_REQ, BANK1}:    irq_flag = irq_flag & ~v[4:0];
						{PORT_IRQ_REQ, BANK2}:    vol[VOL_LR] = v;
						default: ;
					endcase
				end
			end
			OP_PUSH_RESP: begin
				if (RW'(step_ptr(32'(rsp_wr), RESP_DEPTH)) != rsp_rd) begin
					rsp_mem[rsp_wr] = v;
					rsp_wr = RW'(step_ptr(32'(rsp_wr), RESP_DEPTH));
				end
			end
			OP_POP_PARAM: begin
				if (!par_empty) begin
					par_last = par_mem[par_rd];
					par_rd = PW'(step_ptr(32'(par_rd), PARAM_DEPTH));
					par_empty = (par_rd == par_wr);
				end
			end
			OP_PUSH_DATA: begin
				if (SW'(step_ptr(32'(sec_wr), SECTOR_BYTES)) != sec_rd) begin
					sec_mem[sec_wr] = v;
					sec_wr = SW'(step_ptr(32'(sec_wr), SECTOR_BYTES));
				end
			end
			OP_SET_IRQ: irq_flag = irq_flag | v[4:0];
			default: ;
		endcase
		r.popped_parameter = par_last;
		r.command_code     = cmd_latch;
		r.request_bits     = req_bits;
		r.irq_enable_mask  = irq_en;
		r.irq_pending      = irq_flag;
		return r;
	endfunction

	function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errs++;
		end
	endfunction

	// Retire reply beats against the oldest prediction, then predict for the new access beat
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			bank = BANK0;
			for (int i = 0; i < PARAM_DEPTH; i++)
				par_mem[i] = '0;
			for (int i = 0; i < RESP_DEPTH; i++)
				rsp_mem[i] = '0;
			for (int i = 0; i < SECTOR_BYTES; i++)
				sec_mem[i] = '0;
			for (int i = 0; i < 4; i++)
				vol[i] = '0;
			par_rd = '0;
			par_wr = '0;
			par_empty = 1'b1;
			par_last = '0;
			rsp_rd = '0;
			rsp_wr = '0;
			sec_rd = '0;
			sec_wr = '0;
			cmd_latch = '0;
			irq_en = '0;
			irq_flag = '0;
			req_bits = '0;
			due_replies.delete();
		end else begin
			if (res_valid && !res_stall) begin
				if (due_replies.size() == 0) begin
					$error("reply beat arrived with no access waiting for it");
					errs++;
				end else begin
					want = due_replies.pop_front();
					compare_field("read_data", want.read_data, res.read_data);
					compare_field("popped_parameter", want.popped_parameter,
						res.popped_parameter);
					compare_field("command_strobe", 8'(want.command_strobe),
						8'(res.command_strobe));
					compare_field("command_code", want.command_code, res.command_code);
					compare_field("request_bits", 8'(want.request_bits),
						8'(res.request_bits));
					compare_field("irq_enable_mask", 8'(want.irq_enable_mask),
						8'(res.irq_enable_mask));
					compare_field("irq_pending", 8'(want.irq_pending), 8'(res.irq_pending));
				end
			end
			if (req_valid && !req_stall)
				due_replies.push_back(predict_reply(req));
		end
		fail_count <= errs;
		open_replies <= due_replies.size();
	end

endmodule

// ===== dv/cdrom_host_register_interface_unit_tb.sv =====
// Stimulus and verdict for the disc-drive host register interface: drives access beats,
// paces both channels and reports the outcome of the reply checker.
// Depends on cdhri_pkg, cdrom_host_register_interface_unit and cdhri_reply_check.
module cdrom_host_register_interface_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cdhri_pkg::*;

	localparam int unsigned RING_BYTES = SECTOR_BYTES_DEF;
	localparam int RING_W = $clog2(RING_BYTES);
	localparam int RANDOM_ITEMS = 1350;
	localparam int CYCLE_LIMIT  = 40000;

	// Opcodes the block leaves unused
	localparam logic [2:0] OP_UNUSED_LO = 3'd6;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	typedef enum int {PACE_FREE, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_e;

	logic clk, arst_n;
	logic req_valid, req_stall, res_valid, res_stall;
	req_t req;
	res_t res;
	int   fail_count, open_replies;

	int   idle_pct, stall_pct;
	logic hold_long, random_on;
	int   issued;
	int   cycles;

	// Data ring pointers as seen by the stimulus, to keep reads off unwritten slots
	bit          ring_seen [RING_BYTES];
	int unsigned ring_rd, ring_wr;

	cdrom_host_register_interface_unit DUT (
		.clk, .arst_n, .req_valid, .req_stall, .req, .res_valid, .res_stall, .res
	);

	cdhri_reply_check CHK (
		.clk, .arst_n, .req_valid, .req_stall, .req, .res_valid, .res_stall, .res,
		.fail_count, .open_replies
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Receiver: random stall, forced high during the long hold-off
	initial begin
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			res_stall <= hold_long || ($urandom_range(99) < stall_pct);
		end
	end

	// Hold off replies for a long stretch early in the random part so the block backs up
	initial begin
		hold_long = 1'b0;
		wait (random_on);
		repeat (40) @(posedge clk);
		hold_long <= 1'b1;
		repeat (250) @(posedge clk);
		hold_long <= 1'b0;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL");
		$finish;
	end

	function automatic req_t beat(logic [2:0] op, logic [1:0] port, logic [7:0] val);
		return '{opcode: op, port_address: port, byte_value: val};
	endfunction

	function automatic int unsigned ring_next(int unsigned p);
		return (p + 1 >= RING_BYTES) ? 0 : p + 1;
	endfunction

	task automatic set_pace(pace_e mode);
		case (mode)
			PACE_FREE:           begin idle_pct = 0;  stall_pct = 0;  end
			PACE_SENDER_IDLE:    begin idle_pct = 65; stall_pct = 0;  end
			PACE_RECEIVER_STALL: begin idle_pct = 0;  stall_pct = 65; end
			default:             begin idle_pct = 22; stall_pct = 22; end
		endcase
	endtask

	// Offer one beat after a random gap and hold it until accepted
	task automatic offer(input req_t item);
		if (item.opcode == OP_HOST_READ && item.port_address == PORT_PARAM_DATA) begin
			// turn a data read of a never-written slot into a status read
			if (ring_wr == ring_rd && !ring_seen[RING_W'(ring_rd)])
				item.port_address = PORT_STATUS;
			else if (ring_wr != ring_rd)
				ring_rd = ring_next(ring_rd);
		end
		if (item.opcode == OP_PUSH_DATA && ring_next(ring_wr) != ring_rd) begin
			ring_seen[RING_W'(ring_wr)] = 1'b1;
			ring_wr = ring_next(ring_wr);
		end
		if (item.opcode <= OP_SET_IRQ)
			issued++;
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	initial begin
		int n, kind;
		logic [7:0] v;
		req_valid = 1'b0;
		req = '0;
		arst_n = 1'b0;
		random_on = 1'b0;
		ring_rd = 0;
		ring_wr = 0;
		issued = 0;
		set_pace(PACE_FREE);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset view, field extremes, every opcode and the corner cases
		offer(beat(OP_HOST_READ, PORT_STATUS, 8'h00));
		offer(beat(OP_HOST_READ, PORT_CMD_RESP, 8'hFF));
		offer(beat(OP_HOST_READ, PORT_IRQ_REQ, 8'h00));
		offer(beat(OP_HOST_WRITE, PORT_CMD_RESP, 8'hFF));
		offer(beat(OP_HOST_WRITE, PORT_PARAM_DATA, 8'h00));
		offer(beat(OP_HOST_WRITE, PORT_PARAM_DATA, 8'hFF));
		offer(beat(OP_HOST_WRITE, PORT_IRQ_REQ, 8'hE0));
		repeat (3) offer(beat(OP_POP_PARAM, PORT_IRQ_REQ, 8'h00));
		offer(beat(OP_PUSH_RESP, PORT_STATUS, 8'hA5));
		offer(beat(OP_HOST_READ, PORT_STATUS, 8'hFF));
		offer(beat(OP_HOST_READ, PORT_CMD_RESP, 8'h00));
		offer(beat(OP_PUSH_DATA, PORT_CMD_RESP, 8'h5A));
		offer(beat(OP_HOST_READ, PORT_PARAM_DATA, 8'h00));
		offer(beat(OP_SET_IRQ, PORT_STATUS, 8'h04));
		offer(beat(OP_HOST_WRITE, PORT_STATUS, {6'h3F, BANK1}));
		offer(beat(OP_HOST_READ, PORT_IRQ_REQ, 8'h00));
		offer(beat(OP_SET_IRQ, PORT_IRQ_REQ, 8'hFB));
		offer(beat(OP_HOST_READ, PORT_IRQ_REQ, 8'h00));
		offer(beat(OP_HOST_WRITE, PORT_PARAM_DATA, 8'hFF));
		offer(beat(OP_HOST_WRITE, PORT_CMD_RESP, 8'h77));
		offer(beat(OP_HOST_WRITE, PORT_IRQ_REQ, 8'hFF));
		offer(beat(OP_UNUSED_LO, PORT_IRQ_REQ, 8'hFF));
		offer(beat(OP_UNUSED_HI, PORT_STATUS, 8'h00));
		offer(beat(OP_HOST_WRITE, PORT_STATUS, {6'h00, BANK3}));
		offer(beat(OP_HOST_WRITE, PORT_IRQ_REQ, 8'h5C));
		offer(beat(OP_HOST_READ, PORT_IRQ_REQ, 8'h00));

		// Random sequences, pacing rotated every 150 beats
		random_on <= 1'b1;
		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			set_pace(pace_e'((issued / 150) % 4));
			kind = $urandom_range(99);
			if (kind < 20) begin
				// command with its parameters, then firmware pops them
				n = $urandom_range(1, 18);
				offer(beat(OP_HOST_WRITE, PORT_STATUS, {6'($urandom), BANK0}));
				repeat (n) offer(beat(OP_HOST_WRITE, PORT_PARAM_DATA, 8'($urandom)));
				if ($urandom_range(3) == 0)
					offer(beat(OP_HOST_READ, PORT_STATUS, 8'($urandom)));
				offer(beat(OP_HOST_WRITE, PORT_CMD_RESP, 8'($urandom)));
				repeat ($urandom_range(n + 2))
					offer(beat(OP_POP_PARAM, 2'($urandom), 8'($urandom)));
			end else if (kind < 40) begin
				// firmware answers, host collects the response
				n = $urandom_range(1, 18);
				repeat (n) offer(beat(OP_PUSH_RESP, 2'($urandom), 8'($urandom)));
				offer(beat(OP_HOST_READ, PORT_STATUS, 8'($urandom)));
				repeat ($urandom_range(n + 2))
					offer(beat(OP_HOST_READ, PORT_CMD_RESP, 8'($urandom)));
			end else if (kind < 55) begin
				// raise, inspect, enable and acknowledge interrupts
				v = $urandom_range(1) ? 8'(1 << $urandom_range(4)) : 8'($urandom);
				offer(beat(OP_SET_IRQ, 2'($urandom), v));
				offer(beat(OP_HOST_WRITE, PORT_STATUS, {6'($urandom), 1'($urandom), 1'b1}));
				offer(beat(OP_HOST_READ, PORT_IRQ_REQ, 8'($urandom)));
				offer(beat(OP_HOST_WRITE, PORT_STATUS, {6'($urandom), BANK1}));
				if ($urandom_range(1))
					offer(beat(OP_HOST_WRITE, PORT_PARAM_DATA, 8'($urandom)));
				offer(beat(OP_HOST_WRITE, PORT_IRQ_REQ, 8'($urandom)));
				offer(beat(OP_HOST_WRITE, PORT_STATUS, {6'($urandom), 1'($urandom), 1'b0}));
				offer(beat(OP_HOST_READ, PORT_IRQ_REQ, 8'($urandom)));
			end else if (kind < 70) begin
				// sector bytes in, host reads them out
				n = $urandom_range(1, 20);
				repeat (n) offer(beat(OP_PUSH_DATA, 2'($urandom), 8'($urandom)));
				repeat ($urandom_range(n + 2))
					offer(beat(OP_HOST_READ, PORT_PARAM_DATA, 8'($urandom)));
			end else if (kind < 85) begin
				// register write in any bank, then any read
				offer(beat(OP_HOST_WRITE, PORT_STATUS, 8'($urandom)));
				offer(beat(OP_HOST_WRITE, 2'($urandom_range(1, 3)), 8'($urandom)));
				offer(beat(OP_HOST_READ, 2'($urandom), 8'($urandom)));
			end else begin
				repeat ($urandom_range(1, 4))
					offer(beat(3'($urandom), 2'($urandom), 8'($urandom)));
			end
		end
		req_valid <= 1'b0;

		// Drain the outstanding replies, then watch for strays
		@(posedge clk);
		while (open_replies != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/cdhri_pkg.sv
rtl/cdrom_host_register_interface_unit.sv
dv/cdhri_reply_check.sv
dv/cdrom_host_register_interface_unit_tb.sv
